// ===== src/vng_pkg.sv =====
// Package for the vertex normal generator: item codes and fixed field widths.
// No dependencies.
package vng_pkg;
    localparam int IDX_W = 10;
    localparam int POS_W_MAX = 16;
    localparam int NRM_W = 16;
    localparam int VERTEX_DEPTH_DEF = 1024;
    localparam int POS_WIDTH_DEF = 16;
    localparam int ACC_WIDTH_DEF = 40;
    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_FACE = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;
    localparam logic [16:0] UNIT_ONE = 17'd16384;
endpackage

// ===== src/vng_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing beyond its parameters.
module vng_divider #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [NUM_W-1:0]  numer,
    input  logic [DEN_W-1:0]  denom,
    output logic              done,
    output logic [NUM_W-1:0]  quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    assign trial = {rem_reg[DEN_W-1:0], q_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                q_reg    <= numer;
                rem_reg  <= '0;
                den_reg  <= denom;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                if (!diff[DEN_W]) begin
                    rem_reg <= diff;
                    q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
                end else begin
                    rem_reg <= trial;
                    q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
    assign quot = q_reg;
endmodule

// ===== src/vertex_normal_generator_core.sv =====
// Top level of the vertex normal generator: position and accumulator memories,
// face accumulation sequencer and normalization unit. Uses vng_pkg, vng_divider.
//
// Channel | Dir | tdata fields (low bit first)
// s_axis  | in  | func, vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
// m_axis  | out | normal_vertex, normal_x, normal_y, normal_z, degenerate
//
// A load item writes the position of its vertex and clears its accumulator; a
// face item does three position reads, a cross product over three multiply
// steps, a clamp and three accumulator read-modify-writes. A read item runs a
// square root and three divides; a zero or out-of-range read skips them.
// Reset is synchronous; after it a clearing pass over every entry zeroes
// the accumulators with s_tready low. A stalled result blocks the next item.
module vertex_normal_generator_core #(
    parameter int VERTEX_DEPTH = vng_pkg::VERTEX_DEPTH_DEF,
    parameter int POS_WIDTH    = vng_pkg::POS_WIDTH_DEF,
    parameter int ACC_WIDTH    = vng_pkg::ACC_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // func[1:0], vertex_index[11:2], pos_x[27:12], pos_y[43:28], pos_z[59:44],
    // corner_a[69:60], corner_b[79:70], corner_c[89:80]
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // normal_vertex[9:0], normal_x[25:10], normal_y[41:26], normal_z[57:42],
    // degenerate[58]
    output logic [63:0] m_tdata
);
    import vng_pkg::*;

    localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam int PW = POS_WIDTH;
    localparam int DW = PW + 1;
    localparam int MW = 2 * DW;
    localparam int CW = MW + 1;
    localparam int SW = 62;
    localparam int RW = 31;
    localparam int NUMW = 48;
    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_LOAD  = 5'd1;
    localparam logic [4:0] ST_FRA   = 5'd2;
    localparam logic [4:0] ST_FRB   = 5'd3;
    localparam logic [4:0] ST_FRC   = 5'd4;
    localparam logic [4:0] ST_FED   = 5'd5;
    localparam logic [4:0] ST_FM0   = 5'd6;
    localparam logic [4:0] ST_FM1   = 5'd7;
    localparam logic [4:0] ST_FM2   = 5'd8;
    localparam logic [4:0] ST_FCL   = 5'd9;
    localparam logic [4:0] ST_ARD   = 5'd10;
    localparam logic [4:0] ST_AWR   = 5'd11;
    localparam logic [4:0] ST_RRD   = 5'd12;
    localparam logic [4:0] ST_RMAG  = 5'd13;
    localparam logic [4:0] ST_RSH   = 5'd14;
    localparam logic [4:0] ST_RSQ   = 5'd15;
    localparam logic [4:0] ST_RSUM  = 5'd16;
    localparam logic [4:0] ST_RROOT = 5'd17;
    localparam logic [4:0] ST_RDIVS = 5'd18;
    localparam logic [4:0] ST_RDIVW = 5'd19;
    localparam logic [4:0] ST_OUT   = 5'd20;
    localparam logic [4:0] ST_CLR   = 5'd21;

    // Memories.
    logic [3*PW-1:0]        pos_mem [VERTEX_DEPTH];
    logic [3*ACC_WIDTH-1:0] acc_mem [VERTEX_DEPTH];
    logic [3*PW-1:0]        pos_rd;
    logic [3*ACC_WIDTH-1:0] acc_rd;
    logic [AW-1:0]          pos_ra, acc_ra, wa;
    logic                   pos_we, acc_we;
    logic [3*PW-1:0]        pos_wd;
    logic [3*ACC_WIDTH-1:0] acc_wd;

    always_ff @(posedge aclk) begin
        if (pos_we) pos_mem[wa] <= pos_wd;
        pos_rd <= pos_mem[pos_ra];
    end
    always_ff @(posedge aclk) begin
        if (acc_we) acc_mem[wa] <= acc_wd;
        acc_rd <= acc_mem[acc_ra];
    end

    logic [4:0] state_reg;
    logic [95:0] in_reg;
    logic [AW-1:0] idx_reg [3];
    logic [AW-1:0] clr_reg;
    logic [1:0] k_reg;
    logic load_ok_reg;

    logic [IDX_W-1:0] in_vi, in_ca, in_cb, in_cc;
    assign in_vi   = in_reg[11:2];
    assign in_ca   = in_reg[69:60];
    assign in_cb   = in_reg[79:70];
    assign in_cc   = in_reg[89:80];

    function automatic logic in_range(input logic [IDX_W-1:0] v);
        return 32'(v) < VERTEX_DEPTH;
    endfunction

    // Face datapath registers.
    logic signed [PW-1:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic signed [DW-1:0] ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    logic signed [MW-1:0] p0_reg, p1_reg;
    logic signed [CW-1:0] n_reg [3];
    logic signed [ACC_WIDTH-1:0] nc_reg [3];
    logic signed [MW-1:0] prod0, prod1;
    logic [1:0] m_reg;

    always_comb begin
        unique case (m_reg)
            2'd0: begin prod0 = uy_reg * vz_reg; prod1 = uz_reg * vy_reg; end
            2'd1: begin prod0 = uz_reg * vx_reg; prod1 = ux_reg * vz_reg; end
            default: begin prod0 = ux_reg * vy_reg; prod1 = uy_reg * vx_reg; end
        endcase
    end

    function automatic logic signed [ACC_WIDTH-1:0] clamp_c(input logic signed [CW-1:0] v);
        logic signed [CW+ACC_WIDTH:0] w;
        w = (CW+ACC_WIDTH+1)'(v);
        if (w > (CW+ACC_WIDTH+1)'(ACC_MAX)) return ACC_MAX;
        if (w < (CW+ACC_WIDTH+1)'(ACC_MIN)) return ACC_MIN;
        return ACC_WIDTH'(v);
    endfunction

    function automatic logic signed [ACC_WIDTH-1:0] sat_add(
        input logic signed [ACC_WIDTH-1:0] a, input logic signed [ACC_WIDTH-1:0] b);
        logic signed [ACC_WIDTH:0] s;
        s = {a[ACC_WIDTH-1], a} + {b[ACC_WIDTH-1], b};
        if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) return s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        return s[ACC_WIDTH-1:0];
    endfunction

    // Read datapath registers.
    logic [ACC_WIDTH-1:0] mag_reg [3];
    logic [2:0] neg_reg;
    logic [29:0] sm_reg [3];
    logic [SW-1:0] sq_reg [3];
    logic [SW-1:0] s_reg, rem_reg, bit_reg;
    logic [SW-1:0] root_reg;
    logic [RW-1:0] len_reg;
    logic [NRM_W-1:0] q_reg [3];
    logic degen_reg;
    logic [IDX_W-1:0] ovi_reg;

    logic [ACC_WIDTH-1:0] mmax;
    logic [5:0] shamt;
    always_comb begin
        mmax = mag_reg[0];
        if (mag_reg[1] > mmax) mmax = mag_reg[1];
        if (mag_reg[2] > mmax) mmax = mag_reg[2];
        shamt = '0;
        for (int i = ACC_WIDTH - 1; i >= 30; i--) begin
            if (mmax[i] && shamt == 6'd0) shamt = 6'(i - 29);
        end
    end

    // Shared divider for the three components.
    logic div_start, div_done;
    logic [NUMW-1:0] div_num, div_q;
    vng_divider #(.NUM_W(NUMW), .DEN_W(RW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .numer(div_num),
        .denom(len_reg), .done(div_done), .quot(div_q)
    );
    assign div_num = NUMW'({sm_reg[k_reg], 14'd0}) + NUMW'(len_reg >> 1);

    logic [NUMW-1:0] qsat;
    assign qsat = (div_q > NUMW'(UNIT_ONE)) ? NUMW'(UNIT_ONE) : div_q;

    logic [SW-1:0] trial;
    assign trial = root_reg + bit_reg;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        pos_we = 1'b0; acc_we = 1'b0;
        wa = idx_reg[k_reg];
        pos_wd = {in_reg[44+PW-1:44], in_reg[28+PW-1:28], in_reg[12+PW-1:12]};
        acc_wd = {sat_add(ACC_WIDTH'(acc_rd[3*ACC_WIDTH-1:2*ACC_WIDTH]), nc_reg[2]),
                  sat_add(ACC_WIDTH'(acc_rd[2*ACC_WIDTH-1:ACC_WIDTH]), nc_reg[1]),
                  sat_add(ACC_WIDTH'(acc_rd[ACC_WIDTH-1:0]), nc_reg[0])};
        pos_ra = idx_reg[k_reg];
        acc_ra = idx_reg[k_reg];
        div_start = 1'b0;
        if (state_reg == ST_LOAD) begin
            pos_we = load_ok_reg; acc_we = load_ok_reg; acc_wd = '0;
        end
        if (state_reg == ST_CLR) begin
            acc_we = 1'b1; acc_wd = '0; wa = clr_reg;
        end
        if (state_reg == ST_AWR) acc_we = 1'b1;
        if (state_reg == ST_RDIVS) div_start = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
            clr_reg   <= '0;
            m_tvalid  <= 1'b0;
            k_reg     <= '0;
        end else begin
            unique case (state_reg)
                ST_CLR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(VERTEX_DEPTH - 1)) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        in_reg <= s_tdata;
                        k_reg  <= '0;
                        unique case (s_tdata[1:0])
                            FUNC_LOAD: begin
                                idx_reg[0] <= AW'(s_tdata[11:2]);
                                load_ok_reg <= 32'(s_tdata[11:2]) < VERTEX_DEPTH;
                                state_reg <= ST_LOAD;
                            end
                            FUNC_FACE: begin
                                idx_reg[0] <= AW'(s_tdata[69:60]);
                                idx_reg[1] <= AW'(s_tdata[79:70]);
                                idx_reg[2] <= AW'(s_tdata[89:80]);
                                state_reg <= ST_FRA;
                            end
                            FUNC_READ: begin
                                idx_reg[0] <= AW'(s_tdata[11:2]);
                                state_reg <= ST_RRD;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_LOAD: state_reg <= ST_IDLE;
                ST_FRA: begin
                    if (!(in_range(in_ca) && in_range(in_cb) && in_range(in_cc)))
                        state_reg <= ST_IDLE;
                    else begin
                        k_reg <= 2'd1;
                        state_reg <= ST_FRB;
                    end
                end
                ST_FRB: begin
                    {az_reg, ay_reg, ax_reg} <= pos_rd;
                    k_reg <= 2'd2;
                    state_reg <= ST_FRC;
                end
                ST_FRC: begin
                    {bz_reg, by_reg, bx_reg} <= pos_rd;
                    state_reg <= ST_FED;
                end
                ST_FED: begin
                    ux_reg <= DW'(bx_reg) - DW'(ax_reg);
                    uy_reg <= DW'(by_reg) - DW'(ay_reg);
                    uz_reg <= DW'(bz_reg) - DW'(az_reg);
                    vx_reg <= DW'($signed(pos_rd[PW-1:0])) - DW'(ax_reg);
                    vy_reg <= DW'($signed(pos_rd[2*PW-1:PW])) - DW'(ay_reg);
                    vz_reg <= DW'($signed(pos_rd[3*PW-1:2*PW])) - DW'(az_reg);
                    m_reg <= 2'd0;
                    state_reg <= ST_FM0;
                end
                ST_FM0, ST_FM1, ST_FM2: begin
                    p0_reg <= prod0; p1_reg <= prod1;
                    if (state_reg != ST_FM0)
                        n_reg[m_reg - 2'd1] <= CW'(p0_reg) - CW'(p1_reg);
                    m_reg <= m_reg + 2'd1;
                    state_reg <= (state_reg == ST_FM2) ? ST_FCL : state_reg + 5'd1;
                end
                ST_FCL: begin
                    nc_reg[0] <= clamp_c(n_reg[0]);
                    nc_reg[1] <= clamp_c(n_reg[1]);
                    nc_reg[2] <= clamp_c(CW'(p0_reg) - CW'(p1_reg));
                    k_reg <= 2'd0;
                    state_reg <= ST_ARD;
                end
                ST_ARD: state_reg <= ST_AWR;
                ST_AWR: begin
                    if (k_reg == 2'd2) state_reg <= ST_IDLE;
                    else begin
                        k_reg <= k_reg + 2'd1;
                        state_reg <= ST_ARD;
                    end
                end
                ST_RRD: state_reg <= ST_RMAG;
                ST_RMAG: begin
                    for (int i = 0; i < 3; i++) begin
                        neg_reg[i] <= acc_rd[i*ACC_WIDTH+ACC_WIDTH-1];
                        mag_reg[i] <= acc_rd[i*ACC_WIDTH+ACC_WIDTH-1]
                            ? ACC_WIDTH'(-acc_rd[i*ACC_WIDTH +: ACC_WIDTH])
                            : acc_rd[i*ACC_WIDTH +: ACC_WIDTH];
                    end
                    ovi_reg <= in_vi;
                    degen_reg <= !in_range(in_vi) || (acc_rd == '0);
                    state_reg <= (!in_range(in_vi) || (acc_rd == '0)) ? ST_OUT : ST_RSH;
                    for (int i = 0; i < 3; i++) q_reg[i] <= '0;
                end
                ST_RSH: begin
                    for (int i = 0; i < 3; i++) sm_reg[i] <= 30'(mag_reg[i] >> shamt);
                    state_reg <= ST_RSQ;
                end
                ST_RSQ: begin
                    for (int i = 0; i < 3; i++) sq_reg[i] <= SW'(sm_reg[i]) * SW'(sm_reg[i]);
                    state_reg <= ST_RSUM;
                end
                ST_RSUM: begin
                    s_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
                    rem_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
                    root_reg <= '0;
                    bit_reg <= SW'(1) << (SW - 2);
                    state_reg <= ST_RROOT;
                end
                ST_RROOT: begin
                    // One digit pair of the integer square root per cycle.
                    if (bit_reg == '0) begin
                        len_reg <= RW'(root_reg);
                        k_reg <= 2'd0;
                        state_reg <= ST_RDIVS;
                    end else begin
                        if (rem_reg >= trial) begin
                            rem_reg <= rem_reg - trial;
                            root_reg <= (root_reg >> 1) + bit_reg;
                        end else begin
                            root_reg <= root_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                    end
                end
                ST_RDIVS: state_reg <= ST_RDIVW;
                ST_RDIVW: begin
                    if (div_done) begin
                        q_reg[k_reg] <= neg_reg[k_reg] ? NRM_W'(-qsat) : NRM_W'(qsat);
                        if (k_reg == 2'd2) state_reg <= ST_OUT;
                        else begin
                            k_reg <= k_reg + 2'd1;
                            state_reg <= ST_RDIVS;
                        end
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid) m_tvalid <= 1'b1;
                    else if (m_tready) begin
                        m_tvalid <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tdata = {5'd0, degen_reg, q_reg[2], q_reg[1], q_reg[0], ovi_reg};

    logic unused_ok;
    assign unused_ok = ^{s_reg, in_reg[95:90], in_reg[1:0]};

    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("ready while result held");
    a_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pos_we && acc_we && state_reg != ST_LOAD))
        else $error("position write outside load");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped under stall");
    a_deg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && degen_reg |-> m_tdata[57:10] == '0)
        else $error("degenerate normal not zero");
endmodule
